### src/drt_pkg.sv
// Package for the dirty rectangle table: sizes, result codes and the rectangle type.
// No dependencies; used by drt_contain and dirty_rect_table.
`default_nettype none

package drt_pkg;

  // Table size and stored coordinate width.
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned COORD_BITS = 16;

  // Entry index and fill count widths.
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Width of the coordinate and result ports.
  localparam int unsigned PORT_BITS = 16;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_RECT   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Invalidate status codes.
  localparam logic [1:0] STAT_REPLACED = 2'd0;
  localparam logic [1:0] STAT_APPENDED = 2'd1;
  localparam logic [1:0] STAT_DROPPED  = 2'd2;

  // Input actions.
  localparam logic ACT_INVALIDATE = 1'b0;
  localparam logic ACT_DRAIN      = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

endpackage

`default_nettype wire

### src/drt_contain.sv
// Containment test: is a stored rectangle wholly inside a new one.
// Depends on drt_pkg for the rectangle type.
`default_nettype none

module drt_contain (
  input  drt_pkg::rect_t new_rect_i,
  input  drt_pkg::rect_t old_rect_i,
  output logic           inside_o
);
  import drt_pkg::*;

  logic [COORD_BITS:0] new_right, new_bottom, old_right, old_bottom;

  // Right and bottom edges carry one extra bit so they never wrap.
  assign new_right  = {1'b0, new_rect_i.x} + {1'b0, new_rect_i.w};
  assign new_bottom = {1'b0, new_rect_i.y} + {1'b0, new_rect_i.h};
  assign old_right  = {1'b0, old_rect_i.x} + {1'b0, old_rect_i.w};
  assign old_bottom = {1'b0, old_rect_i.y} + {1'b0, old_rect_i.h};

  assign inside_o = (new_rect_i.x <= old_rect_i.x) && (new_rect_i.y <= old_rect_i.y) &&
                    (new_right >= old_right) && (new_bottom >= old_bottom);

endmodule

`default_nettype wire

### src/dirty_rect_table.sv
// Dirty rectangle table top level; depends on drt_pkg and drt_contain.
// One item at a time: the input stalls until the item's last result is loaded for output.
// Invalidate scans the entries, one read per cycle from registered read data; an entry
// the new rectangle contains is replaced, else the request is appended; a full table drops it.
// Drain returns every entry, the last one marked, then empties the table; an empty drain gives
// an EMPTY result. Reset clears control state and fill count; entry contents are left as they are.
`default_nettype none

module dirty_rect_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [15:0] rect_x_o,
  output logic [15:0] rect_y_o,
  output logic [15:0] rect_width_o,
  output logic [15:0] rect_height_o,
  output logic        last_o
);
  import drt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q;
  rect_t              req_q;
  logic [1:0]         res_kind_q, res_kind_d;
  logic [1:0]         res_status_q, res_status_d;

  // Entry memory with registered read data.
  rect_t              mem [DEPTH];
  rect_t              mem_rdata_q;
  logic               mem_re, mem_we;
  logic [IDX_W-1:0]   mem_waddr;

  logic               out_valid_q;
  logic               in_xfer, out_free, issue_more, contained;
  logic               found, append, drain_load, resp_load, drain_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue_more = (issue_q < count_q);

  drt_contain u_contain (
    .new_rect_i (req_q),
    .old_rect_i (mem_rdata_q),
    .inside_o   (contained)
  );

  // Decisions of the scan and drain passes.
  assign found      = (state_q == S_SCAN) && rd_vld_q && contained;
  assign append     = (state_q == S_SCAN) && !issue_more && !rd_vld_q;
  assign drain_load = (state_q == S_DRAIN) && rd_vld_q && out_free;
  assign drain_last = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);
  assign resp_load  = (state_q == S_RESP) && out_free;

  // Read issue: the scan reads every cycle; the drain reads only when the data has a place.
  always_comb begin
    mem_re = 1'b0;
    if (state_q == S_SCAN) begin
      mem_re = issue_more && !found;
    end else if (state_q == S_DRAIN) begin
      mem_re = issue_more && (!rd_vld_q || drain_load);
    end
  end

  // Write back on a replace or an append.
  assign mem_we    = found || append;
  assign mem_waddr = found ? rd_idx_q : count_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_q;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[issue_q[IDX_W-1:0]];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    rd_vld_d     = rd_vld_q;
    res_kind_d   = res_kind_q;
    res_status_d = res_status_q;
    if (mem_re) begin
      issue_d = issue_q + CNT_W'(1);
    end
    case (state_q)
      S_IDLE: begin
        issue_d  = '0;
        rd_vld_d = 1'b0;
        if (in_xfer) begin
          res_kind_d   = KIND_STATUS;
          res_status_d = STAT_DROPPED;
          if (action_i == ACT_INVALIDATE) begin
            state_d = (count_q == CNT_W'(DEPTH)) ? S_RESP : S_SCAN;
          end else if (count_q == '0) begin
            res_kind_d   = KIND_EMPTY;
            res_status_d = STAT_REPLACED;
            state_d      = S_RESP;
          end else begin
            state_d = S_DRAIN;
          end
        end
      end
      S_SCAN: begin
        rd_vld_d = mem_re;
        if (found) begin
          res_status_d = STAT_REPLACED;
          state_d      = S_RESP;
        end else if (append) begin
          count_d      = count_q + CNT_W'(1);
          res_status_d = STAT_APPENDED;
          state_d      = S_RESP;
        end
      end
      S_DRAIN: begin
        if (mem_re) begin
          rd_vld_d = 1'b1;
        end else if (drain_load) begin
          rd_vld_d = 1'b0;
        end
        if (drain_load && drain_last) begin
          count_d = '0;
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      if (drain_load || resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request, pending result code, read index and result fields.
  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    if (in_xfer) begin
      req_q.x <= x_i[COORD_BITS-1:0];
      req_q.y <= y_i[COORD_BITS-1:0];
      req_q.w <= width_i[COORD_BITS-1:0];
      req_q.h <= height_i[COORD_BITS-1:0];
    end
    if (mem_re) begin
      rd_idx_q <= issue_q[IDX_W-1:0];
    end
    if (drain_load) begin
      kind_o        <= KIND_RECT;
      status_o      <= STAT_REPLACED;
      rect_x_o      <= PORT_BITS'(mem_rdata_q.x);
      rect_y_o      <= PORT_BITS'(mem_rdata_q.y);
      rect_width_o  <= PORT_BITS'(mem_rdata_q.w);
      rect_height_o <= PORT_BITS'(mem_rdata_q.h);
      last_o        <= drain_last;
    end else if (resp_load) begin
      kind_o        <= res_kind_q;
      status_o      <= res_status_q;
      rect_x_o      <= '0;
      rect_y_o      <= '0;
      rect_width_o  <= '0;
      rect_height_o <= '0;
      last_o        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
